// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the files that check their own logic.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low reset that disables the check.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ewsc_pkg.sv =====
// Shared constants, codes and control structs of the step centroid core.
// Depends on nothing; used by the interfaces, controller, datapath and top.
`timescale 1ns / 1ps

package ewsc_pkg;

  localparam int ENERGY_BITS_DEF = 32;
  localparam int SUM_BITS_DEF    = 48;
  localparam int POS_BITS_DEF    = 32;
  localparam int ID_BITS         = 31;
  localparam int KIND_BITS       = 16;
  localparam int COUNT_BITS      = 32;
  localparam int ROLL_BITS       = 2;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [ROLL_BITS-1:0] ROLL_NONE  = 2'd0;
  localparam logic [ROLL_BITS-1:0] ROLL_EVENT = 2'd1;
  localparam logic [ROLL_BITS-1:0] ROLL_TRACK = 2'd2;

  localparam logic [1:0] AXIS_LAST = 2'd2;

  typedef struct packed {
    logic       load;
    logic       check;
    logic       axis_init;
    logic       mul_step;
    logic       combine;
    logic       div_step;
    logic       store;
    logic       sums;
    logic       publish;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic drop;
  } status_t;

endpackage

// ===== hw/rtl/ewsc_step_if.sv =====
// Input channel carrying one simulation step or a clear command.
// Depends on ewsc_pkg for the default field widths.
`timescale 1ns / 1ps

interface ewsc_step_if #(
  parameter int ENERGY_BITS = ewsc_pkg::ENERGY_BITS_DEF,
  parameter int POS_BITS    = ewsc_pkg::POS_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic [ewsc_pkg::ID_BITS-1:0]      event_number;
  logic [ewsc_pkg::ID_BITS-1:0]      track_number;
  logic [ewsc_pkg::KIND_BITS-1:0]    particle_kind;
  logic [ENERGY_BITS-1:0]            ionizing_energy;
  logic [ENERGY_BITS-1:0]            nonionizing_energy;
  logic signed [POS_BITS-1:0]        pre_x;
  logic signed [POS_BITS-1:0]        pre_y;
  logic signed [POS_BITS-1:0]        pre_z;
  logic signed [POS_BITS-1:0]        post_x;
  logic signed [POS_BITS-1:0]        post_y;
  logic signed [POS_BITS-1:0]        post_z;

  modport source (
    output valid, command, event_number, track_number, particle_kind,
           ionizing_energy, nonionizing_energy, pre_x, pre_y, pre_z,
           post_x, post_y, post_z,
    input  ready
  );
  modport sink (
    input  valid, command, event_number, track_number, particle_kind,
           ionizing_energy, nonionizing_energy, pre_x, pre_y, pre_z,
           post_x, post_y, post_z,
    output ready
  );
endinterface

// ===== hw/rtl/ewsc_result_if.sv =====
// Output channel carrying the accumulation state after one transaction.
// Depends on ewsc_pkg for the default field widths.
`timescale 1ns / 1ps

interface ewsc_result_if #(
  parameter int SUM_BITS = ewsc_pkg::SUM_BITS_DEF,
  parameter int POS_BITS = ewsc_pkg::POS_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [ewsc_pkg::ROLL_BITS-1:0]    rollover_kind;
  logic                              rejected;
  logic [ewsc_pkg::COUNT_BITS-1:0]   step_count;
  logic [SUM_BITS-1:0]               ionizing_sum;
  logic [SUM_BITS-1:0]               nonionizing_sum;
  logic signed [POS_BITS-1:0]        start_x;
  logic signed [POS_BITS-1:0]        start_y;
  logic signed [POS_BITS-1:0]        start_z;
  logic signed [POS_BITS-1:0]        centroid_x;
  logic signed [POS_BITS-1:0]        centroid_y;
  logic signed [POS_BITS-1:0]        centroid_z;

  modport source (
    output valid, rollover_kind, rejected, step_count, ionizing_sum,
           nonionizing_sum, start_x, start_y, start_z,
           centroid_x, centroid_y, centroid_z,
    input  ready
  );
  modport sink (
    input  valid, rollover_kind, rejected, step_count, ionizing_sum,
           nonionizing_sum, start_x, start_y, start_z,
           centroid_x, centroid_y, centroid_z,
    output ready
  );
endinterface

// ===== hw/rtl/ewsc_datapath.sv =====
// Datapath: step registers, accumulation state, serial multipliers and divider.
// Depends on ewsc_pkg for the command and status structs and the codes.
`timescale 1ns / 1ps

module ewsc_datapath #(
  parameter int ENERGY_BITS = ewsc_pkg::ENERGY_BITS_DEF,
  parameter int SUM_BITS    = ewsc_pkg::SUM_BITS_DEF,
  parameter int POS_BITS    = ewsc_pkg::POS_BITS_DEF,
  localparam int MW = (SUM_BITS > ENERGY_BITS) ? SUM_BITS : ENERGY_BITS,
  localparam int DW = MW + 1,
  localparam int NW = POS_BITS + MW + 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ewsc_pkg::cmd_t                   cmd_i,
  output ewsc_pkg::status_t                status_o,
  input  logic                             command_i,
  input  logic [ewsc_pkg::ID_BITS-1:0]     event_i,
  input  logic [ewsc_pkg::ID_BITS-1:0]     track_i,
  input  logic [ewsc_pkg::KIND_BITS-1:0]   kind_i,
  input  logic [ENERGY_BITS-1:0]           ion_i,
  input  logic [ENERGY_BITS-1:0]           nion_i,
  input  logic [2:0][POS_BITS-1:0]         pre_i,
  input  logic [2:0][POS_BITS-1:0]         post_i,
  output logic [ewsc_pkg::ROLL_BITS-1:0]   roll_o,
  output logic                             rej_o,
  output logic [ewsc_pkg::COUNT_BITS-1:0]  count_o,
  output logic [SUM_BITS-1:0]              ion_sum_o,
  output logic [SUM_BITS-1:0]              nion_sum_o,
  output logic [2:0][POS_BITS-1:0]         start_o,
  output logic [2:0][POS_BITS-1:0]         cent_o
);

  localparam logic [ewsc_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  logic                             cmd_q;
  logic [ewsc_pkg::ID_BITS-1:0]     ev_q, tr_q;
  logic [ewsc_pkg::KIND_BITS-1:0]   kind_q;
  logic [ENERGY_BITS-1:0]           ion_q, nion_q;
  logic [2:0][POS_BITS-1:0]         pre_q, post_q;

  logic                             ev_valid_q, ev_valid_d, tr_valid_q, tr_valid_d;
  logic [ewsc_pkg::ID_BITS-1:0]     ev_st_q, ev_st_d, tr_st_q, tr_st_d;
  logic [ewsc_pkg::KIND_BITS-1:0]   kind_st_q, kind_st_d;
  logic [ewsc_pkg::COUNT_BITS-1:0]  count_q, count_d, count_eff;
  logic [SUM_BITS-1:0]              ion_acc_q, ion_acc_d, nion_acc_q, nion_acc_d;
  logic [2:0][POS_BITS-1:0]         start_q, start_d, cent_q, cent_d;
  logic [ewsc_pkg::ROLL_BITS-1:0]   roll_q, roll_d;
  logic                             rej_q, rej_d;

  logic [NW-1:0]       mcand_a_q, mcand_b_q, prod_a_q, prod_b_q, num_q;
  logic [MW-1:0]       mplier_a_q, mplier_b_q;
  logic                neg_p_q, neg_q_q, neg_q;
  logic [DW-1:0]       rem_q;
  logic [POS_BITS-1:0] quo_q;

  logic                evchg, trchg, is_clear, rej, wipe, trivial;
  logic [POS_BITS-1:0] pos_p, pos_q, mag_p, mag_q, res_mag, res_val;
  logic [DW:0]         shifted, diff;
  logic [DW-1:0]       den, ion_sum, nion_sum;

  assign is_clear = (cmd_q == ewsc_pkg::CMD_CLEAR);
  assign evchg    = ev_valid_q && (ev_st_q != ev_q);
  assign trchg    = tr_valid_q && ((tr_st_q != tr_q) || (kind_st_q != kind_q));
  assign wipe     = is_clear || evchg || trchg;
  assign rej      = !is_clear && (ion_q == '0) && (nion_q == '0);
  assign count_eff = wipe ? '0 : count_q;
  assign status_o.drop = is_clear || rej;
  assign trivial  = (ion_acc_q == '0) && (ion_q == '0);

  assign pos_p = cent_q[cmd_i.axis];
  assign pos_q = post_q[cmd_i.axis];
  assign mag_p = pos_p[POS_BITS-1] ? (~pos_p + 1'b1) : pos_p;
  assign mag_q = pos_q[POS_BITS-1] ? (~pos_q + 1'b1) : pos_q;

  assign den      = DW'(ion_acc_q) + DW'(ion_q);
  assign ion_sum  = DW'(ion_acc_q) + DW'(ion_q);
  assign nion_sum = DW'(nion_acc_q) + DW'(nion_q);
  assign shifted  = {rem_q, num_q[NW-1]};
  assign diff     = shifted - {1'b0, den};

  assign res_mag = quo_q;
  assign res_val = (neg_q && (res_mag != '0)) ? (~res_mag + 1'b1) : res_mag;

  always_comb begin
    ev_valid_d = ev_valid_q;
    ev_st_d    = ev_st_q;
    tr_valid_d = tr_valid_q;
    tr_st_d    = tr_st_q;
    kind_st_d  = kind_st_q;
    count_d    = count_q;
    ion_acc_d  = ion_acc_q;
    nion_acc_d = nion_acc_q;
    start_d    = start_q;
    cent_d     = cent_q;
    roll_d     = roll_q;
    rej_d      = rej_q;
    if (cmd_i.check) begin
      rej_d = rej;
      if (is_clear) begin
        roll_d = ewsc_pkg::ROLL_NONE;
      end else if (evchg) begin
        roll_d = ewsc_pkg::ROLL_EVENT;
      end else if (trchg) begin
        roll_d = ewsc_pkg::ROLL_TRACK;
      end else begin
        roll_d = ewsc_pkg::ROLL_NONE;
      end
      if (wipe) begin
        ev_valid_d = 1'b0;
        ev_st_d    = '0;
        tr_valid_d = 1'b0;
        tr_st_d    = '0;
        kind_st_d  = '0;
        count_d    = '0;
        ion_acc_d  = '0;
        nion_acc_d = '0;
        start_d    = '0;
        cent_d     = '0;
      end
      if (!is_clear && !rej) begin
        if (count_eff == '0) begin
          ev_valid_d = 1'b1;
          ev_st_d    = ev_q;
          tr_valid_d = 1'b1;
          tr_st_d    = tr_q;
          kind_st_d  = kind_q;
          start_d    = pre_q;
        end
        count_d = (count_eff == COUNT_MAX) ? count_eff : count_eff + 1'b1;
      end
    end
    if (cmd_i.store) begin
      cent_d[cmd_i.axis] = trivial ? pos_q : res_val;
    end
    if (cmd_i.sums) begin
      ion_acc_d  = (ion_sum > DW'(SUM_MAX)) ? SUM_MAX : ion_sum[SUM_BITS-1:0];
      nion_acc_d = (nion_sum > DW'(SUM_MAX)) ? SUM_MAX : nion_sum[SUM_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
      ev_st_q    <= '0;
      tr_valid_q <= 1'b0;
      tr_st_q    <= '0;
      kind_st_q  <= '0;
      count_q    <= '0;
      ion_acc_q  <= '0;
      nion_acc_q <= '0;
      start_q    <= '0;
      cent_q     <= '0;
    end else begin
      ev_valid_q <= ev_valid_d;
      ev_st_q    <= ev_st_d;
      tr_valid_q <= tr_valid_d;
      tr_st_q    <= tr_st_d;
      kind_st_q  <= kind_st_d;
      count_q    <= count_d;
      ion_acc_q  <= ion_acc_d;
      nion_acc_q <= nion_acc_d;
      start_q    <= start_d;
      cent_q     <= cent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    roll_q <= roll_d;
    rej_q  <= rej_d;
    if (cmd_i.load) begin
      cmd_q  <= command_i;
      ev_q   <= event_i;
      tr_q   <= track_i;
      kind_q <= kind_i;
      ion_q  <= ion_i;
      nion_q <= nion_i;
      pre_q  <= pre_i;
      post_q <= post_i;
    end
    if (cmd_i.axis_init) begin
      mcand_a_q  <= NW'(mag_p);
      mcand_b_q  <= NW'(mag_q);
      mplier_a_q <= MW'(ion_acc_q);
      mplier_b_q <= MW'(ion_q);
      prod_a_q   <= '0;
      prod_b_q   <= '0;
      neg_p_q    <= pos_p[POS_BITS-1];
      neg_q_q    <= pos_q[POS_BITS-1];
    end
    if (cmd_i.mul_step) begin
      prod_a_q   <= prod_a_q + (mplier_a_q[0] ? mcand_a_q : '0);
      prod_b_q   <= prod_b_q + (mplier_b_q[0] ? mcand_b_q : '0);
      mcand_a_q  <= {mcand_a_q[NW-2:0], 1'b0};
      mcand_b_q  <= {mcand_b_q[NW-2:0], 1'b0};
      mplier_a_q <= {1'b0, mplier_a_q[MW-1:1]};
      mplier_b_q <= {1'b0, mplier_b_q[MW-1:1]};
    end
    if (cmd_i.combine) begin
      rem_q <= '0;
      quo_q <= '0;
      if (neg_p_q == neg_q_q) begin
        num_q <= prod_a_q + prod_b_q;
        neg_q <= neg_p_q;
      end else if (prod_a_q >= prod_b_q) begin
        num_q <= prod_a_q - prod_b_q;
        neg_q <= neg_p_q;
      end else begin
        num_q <= prod_b_q - prod_a_q;
        neg_q <= neg_q_q;
      end
    end
    if (cmd_i.div_step) begin
      num_q <= {num_q[NW-2:0], 1'b0};
      if (!diff[DW]) begin
        rem_q <= diff[DW-1:0];
        quo_q <= {quo_q[POS_BITS-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DW-1:0];
        quo_q <= {quo_q[POS_BITS-2:0], 1'b0};
      end
    end
    if (cmd_i.publish) begin
      roll_o     <= roll_q;
      rej_o      <= rej_q;
      count_o    <= count_q;
      ion_sum_o  <= ion_acc_q;
      nion_sum_o <= nion_acc_q;
      start_o    <= start_q;
      cent_o     <= cent_q;
    end
  end

endmodule

// ===== hw/rtl/ewsc_ctrl.sv =====
// Controller: sequences check, serial multiply, divide and publish per axis.
// Depends on ewsc_pkg for the command and status structs.
`timescale 1ns / 1ps

module ewsc_ctrl #(
  parameter int ENERGY_BITS = ewsc_pkg::ENERGY_BITS_DEF,
  parameter int SUM_BITS    = ewsc_pkg::SUM_BITS_DEF,
  parameter int POS_BITS    = ewsc_pkg::POS_BITS_DEF,
  localparam int MW = (SUM_BITS > ENERGY_BITS) ? SUM_BITS : ENERGY_BITS,
  localparam int NW = POS_BITS + MW + 1,
  localparam int CW = $clog2(NW)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ewsc_pkg::status_t status_i,
  output ewsc_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_INIT   = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_COMB   = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_STORE  = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [1:0]    axis_q, axis_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.axis  = axis_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        axis_d      = '0;
        state_d     = status_i.drop ? ST_FINISH : ST_INIT;
      end
      ST_INIT: begin
        cmd_o.axis_init = 1'b1;
        cnt_d           = '0;
        state_d         = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CW'(MW - 1)) begin
          state_d = ST_COMB;
        end
      end
      ST_COMB: begin
        cmd_o.combine = 1'b1;
        cnt_d         = '0;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CW'(NW - 1)) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        if (axis_q == ewsc_pkg::AXIS_LAST) begin
          cmd_o.sums = 1'b1;
          state_d    = ST_FINISH;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = ST_INIT;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hw/rtl/energy_weighted_step_centroid_core.sv =====
// Each transaction takes one step or a clear command and returns one result:
// the rollover report, the reject flag and the accumulation state after it.
// A clear, or a step with both energies zero, goes from the check straight
// to publishing its result. For any other step, with
// MW = max(SUM_BITS, ENERGY_BITS) and NW = POS_BITS + MW + 1, for each axis a
// bit-serial multiplier forms both weighted products over the MW multiplier
// bits and a restoring divider works through the NW numerator bits.
// One step is in work at a time; a new one is accepted while the last result
// still waits in the output register.
// Depends on ewsc_pkg, the two channel interfaces, ewsc_ctrl, ewsc_datapath.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module energy_weighted_step_centroid_core #(
  parameter int ENERGY_BITS = ewsc_pkg::ENERGY_BITS_DEF,
  parameter int SUM_BITS    = ewsc_pkg::SUM_BITS_DEF,
  parameter int POS_BITS    = ewsc_pkg::POS_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ewsc_step_if.sink     step_i,
  ewsc_result_if.source result_o
);

  ewsc_pkg::cmd_t           cmd;
  ewsc_pkg::status_t        status;
  logic [2:0][POS_BITS-1:0] pre, post, start, cent;

  assign pre  = {step_i.pre_z, step_i.pre_y, step_i.pre_x};
  assign post = {step_i.post_z, step_i.post_y, step_i.post_x};

  ewsc_ctrl #(
    .ENERGY_BITS(ENERGY_BITS),
    .SUM_BITS   (SUM_BITS),
    .POS_BITS   (POS_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (step_i.valid),
    .in_ready_o (step_i.ready),
    .out_valid_o(result_o.valid),
    .out_ready_i(result_o.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ewsc_datapath #(
    .ENERGY_BITS(ENERGY_BITS),
    .SUM_BITS   (SUM_BITS),
    .POS_BITS   (POS_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .command_i (step_i.command),
    .event_i   (step_i.event_number),
    .track_i   (step_i.track_number),
    .kind_i    (step_i.particle_kind),
    .ion_i     (step_i.ionizing_energy),
    .nion_i    (step_i.nonionizing_energy),
    .pre_i     (pre),
    .post_i    (post),
    .roll_o    (result_o.rollover_kind),
    .rej_o     (result_o.rejected),
    .count_o   (result_o.step_count),
    .ion_sum_o (result_o.ionizing_sum),
    .nion_sum_o(result_o.nonionizing_sum),
    .start_o   (start),
    .cent_o    (cent)
  );

  assign result_o.start_x    = start[0];
  assign result_o.start_y    = start[1];
  assign result_o.start_z    = start[2];
  assign result_o.centroid_x = cent[0];
  assign result_o.centroid_y = cent[1];
  assign result_o.centroid_z = cent[2];

  `ASSERT_CLK(a_accept_then_busy, clk_i, rst_ni, (step_i.valid && step_i.ready) |=> !step_i.ready, "ready stayed high after a transaction")
  `ASSERT_CLK(a_load_then_check, clk_i, rst_ni, cmd.load |=> cmd.check, "check did not follow an accepted transaction")
  `ASSERT_CLK(a_publish_valid, clk_i, rst_ni, cmd.publish |=> result_o.valid, "published result not presented")

endmodule

// ===== tb/ewsc_centroid_checker.sv =====
// Checker for the step centroid core: watches the step and result channels,
// predicts each result from the accepted steps and compares it field by field.
// Depends on ewsc_pkg and the two channel interfaces.
`timescale 1ns / 1ps

module ewsc_centroid_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ewsc_step_if        step_mon,
  ewsc_result_if      res_mon,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [1:0]         roll;
    logic               rej;
    logic [31:0]        count;
    logic [47:0]        ion;
    logic [47:0]        nion;
    logic [2:0][31:0]   start;
    logic [2:0][31:0]   cent;
  } summary_t;

  localparam logic [47:0] SUM_MAX = {48{1'b1}};

  logic        ev_ok, tr_ok;
  logic [30:0] ev_id, tr_id;
  logic [15:0] kind_id;
  logic [31:0] steps;
  logic [47:0] ion_acc, nion_acc;
  logic [2:0][31:0] start_p, cent_p;
  summary_t    expected_q[$];

  function automatic logic [47:0] sat_sum(logic [47:0] a, logic [31:0] e);
    logic [48:0] s;
    s = {1'b0, a} + e;
    return s[48] ? SUM_MAX : s[47:0];
  endfunction

  function automatic logic [31:0] blend(logic [31:0] p, logic [47:0] a,
                                        logic [31:0] q, logic [31:0] b);
    logic signed [127:0] num, den, quo;
    num = $signed({{96{p[31]}}, p}) * $signed({80'd0, a})
        + $signed({{96{q[31]}}, q}) * $signed({96'd0, b});
    den = $signed({80'd0, a}) + $signed({96'd0, b});
    quo = num / den;
    return quo[31:0];
  endfunction

  task automatic wipe();
    ev_ok = 0; tr_ok = 0; ev_id = '0; tr_id = '0; kind_id = '0;
    steps = '0; ion_acc = '0; nion_acc = '0; start_p = '0; cent_p = '0;
  endtask

  task automatic absorb_step();
    summary_t r;
    logic [2:0][31:0] pre, post;
    r = '0;
    pre  = {step_mon.pre_z, step_mon.pre_y, step_mon.pre_x};
    post = {step_mon.post_z, step_mon.post_y, step_mon.post_x};
    if (step_mon.command == ewsc_pkg::CMD_CLEAR) begin
      wipe();
    end else begin
      if (ev_ok && ev_id != step_mon.event_number) begin
        wipe(); r.roll = ewsc_pkg::ROLL_EVENT;
      end
      if (tr_ok && (tr_id != step_mon.track_number || kind_id != step_mon.particle_kind)) begin
        wipe(); r.roll = ewsc_pkg::ROLL_TRACK;
      end
      if (step_mon.ionizing_energy == 0 && step_mon.nonionizing_energy == 0) begin
        r.rej = 1;
      end else begin
        if (steps == 0) begin
          ev_ok = 1; tr_ok = 1; ev_id = step_mon.event_number;
          tr_id = step_mon.track_number; kind_id = step_mon.particle_kind;
          start_p = pre;
        end
        if (steps != '1) steps++;
        for (int i = 0; i < 3; i++)
          if (ion_acc == 0 && step_mon.ionizing_energy == 0) cent_p[i] = post[i];
          else cent_p[i] = blend(cent_p[i], ion_acc, post[i], step_mon.ionizing_energy);
        ion_acc  = sat_sum(ion_acc, step_mon.ionizing_energy);
        nion_acc = sat_sum(nion_acc, step_mon.nonionizing_energy);
      end
    end
    r.count = steps; r.ion = ion_acc; r.nion = nion_acc;
    r.start = start_p; r.cent = cent_p;
    expected_q.push_back(r);
  endtask

  task automatic compare_result();
    summary_t e;
    if (expected_q.size() == 0) begin
      $error("result with no expected transaction");
      errors_o++;
      return;
    end
    e = expected_q.pop_front();
    if (res_mon.rollover_kind !== e.roll) begin
      $error("rollover_kind exp %0d got %0d", e.roll, res_mon.rollover_kind); errors_o++;
    end
    if (res_mon.rejected !== e.rej) begin
      $error("rejected exp %0d got %0d", e.rej, res_mon.rejected); errors_o++;
    end
    if (res_mon.step_count !== e.count) begin
      $error("step_count exp %0d got %0d", e.count, res_mon.step_count); errors_o++;
    end
    if (res_mon.ionizing_sum !== e.ion) begin
      $error("ionizing_sum exp %0d got %0d", e.ion, res_mon.ionizing_sum); errors_o++;
    end
    if (res_mon.nonionizing_sum !== e.nion) begin
      $error("nonionizing_sum exp %0d got %0d", e.nion, res_mon.nonionizing_sum); errors_o++;
    end
    if (res_mon.start_x !== e.start[0]) begin
      $error("start_x exp %0d got %0d", $signed(e.start[0]), res_mon.start_x); errors_o++;
    end
    if (res_mon.start_y !== e.start[1]) begin
      $error("start_y exp %0d got %0d", $signed(e.start[1]), res_mon.start_y); errors_o++;
    end
    if (res_mon.start_z !== e.start[2]) begin
      $error("start_z exp %0d got %0d", $signed(e.start[2]), res_mon.start_z); errors_o++;
    end
    if (res_mon.centroid_x !== e.cent[0]) begin
      $error("centroid_x exp %0d got %0d", $signed(e.cent[0]), res_mon.centroid_x); errors_o++;
    end
    if (res_mon.centroid_y !== e.cent[1]) begin
      $error("centroid_y exp %0d got %0d", $signed(e.cent[1]), res_mon.centroid_y); errors_o++;
    end
    if (res_mon.centroid_z !== e.cent[2]) begin
      $error("centroid_z exp %0d got %0d", $signed(e.cent[2]), res_mon.centroid_z); errors_o++;
    end
  endtask

  initial begin
    errors_o = 0;
    wipe();
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_mon.valid && res_mon.ready) compare_result();
      if (step_mon.valid && step_mon.ready) absorb_step();
    end
    pending_o <= expected_q.size();
  end
endmodule

// ===== tb/tb_energy_weighted_step_centroid_core.sv =====
// Top of the step centroid core testbench: clock, reset, step stimulus with
// random idling on both channels, and the verdict. Depends on ewsc_pkg, the
// channel interfaces, the core and ewsc_centroid_checker.
`timescale 1ns / 1ps

module tb_energy_weighted_step_centroid_core;

  localparam longint CYCLE_LIMIT = 3000000;

  logic clk_i = 0;
  logic rst_ni = 0;
  int   errors, pending;
  int   send_idle, recv_idle;
  longint cycles = 0;
  logic [30:0] cur_ev, cur_tr;
  logic [15:0] cur_kind;

  ewsc_step_if   step_ch ();
  ewsc_result_if res_ch ();

  energy_weighted_step_centroid_core dut (
    .clk_i (clk_i), .rst_ni (rst_ni), .step_i (step_ch), .result_o (res_ch)
  );

  ewsc_centroid_checker chk (
    .clk_i (clk_i), .rst_ni (rst_ni), .step_mon (step_ch), .res_mon (res_ch),
    .errors_o (errors), .pending_o (pending)
  );

  initial forever #5 clk_i = ~clk_i;

  initial begin
    step_ch.valid = 0; step_ch.command = ewsc_pkg::CMD_ADD; step_ch.event_number = '0;
    step_ch.track_number = '0; step_ch.particle_kind = '0;
    step_ch.ionizing_energy = '0; step_ch.nonionizing_energy = '0;
    step_ch.pre_x = '0; step_ch.pre_y = '0; step_ch.pre_z = '0;
    step_ch.post_x = '0; step_ch.post_y = '0; step_ch.post_z = '0;
    res_ch.ready = 0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) res_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [31:0] rand_energy();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(40) - 20;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic cmd, logic [30:0] ev, logic [30:0] tr, logic [15:0] kind,
                      logic [31:0] ion, logic [31:0] nion,
                      logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                      logic [31:0] qx, logic [31:0] qy, logic [31:0] qz);
    while ($urandom_range(99) < send_idle) begin
      step_ch.valid <= 0;
      @(posedge clk_i);
    end
    step_ch.valid <= 1; step_ch.command <= cmd; step_ch.event_number <= ev;
    step_ch.track_number <= tr; step_ch.particle_kind <= kind;
    step_ch.ionizing_energy <= ion; step_ch.nonionizing_energy <= nion;
    step_ch.pre_x <= px; step_ch.pre_y <= py; step_ch.pre_z <= pz;
    step_ch.post_x <= qx; step_ch.post_y <= qy; step_ch.post_z <= qz;
    do @(posedge clk_i); while (!step_ch.ready);
  endtask

  task automatic send_random();
    int pick;
    pick = $urandom_range(99);
    if (pick < 4) begin
      cur_ev = $urandom; cur_tr = $urandom; cur_kind = $urandom;
    end else if (pick < 8) begin
      cur_tr = $urandom;
    end else if (pick < 10) begin
      cur_kind = $urandom;
    end
    send(pick >= 97 ? ewsc_pkg::CMD_CLEAR : ewsc_pkg::CMD_ADD, cur_ev, cur_tr, cur_kind,
         rand_energy(), rand_energy(), rand_pos(), rand_pos(), rand_pos(),
         rand_pos(), rand_pos(), rand_pos());
  endtask

  initial begin
    send_idle = 11; recv_idle = 58;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send(ewsc_pkg::CMD_ADD, 31'h7fffffff, 31'h7fffffff, 16'hffff, '0, '0, 1, 2, 3, 4, 5, 6);
    send(ewsc_pkg::CMD_ADD, 5, 7, 3, 0, 9, -10, 20, 30, 100, -200, 300);
    send(ewsc_pkg::CMD_ADD, 5, 7, 3, '1, '1, 32'h80000000, 32'h7fffffff, 0,
         32'h7fffffff, 32'h80000000, -1);
    send(ewsc_pkg::CMD_ADD, 5, 7, 3, '1, '1, 0, 0, 0, 32'h80000000, 32'h7fffffff, 7);
    send(ewsc_pkg::CMD_ADD, 5, 7, 3, 1, 0, 1, 1, 1, -7, 7, -1);
    send(ewsc_pkg::CMD_ADD, 5, 7, 3, 0, 0, 1, 1, 1, 1, 1, 1);
    send(ewsc_pkg::CMD_ADD, 5, 8, 3, 3, 1, 9, 9, 9, -3, 3, 0);
    send(ewsc_pkg::CMD_ADD, 5, 8, 4, 0, 0, 0, 0, 0, 0, 0, 0);
    send(ewsc_pkg::CMD_ADD, 5, 8, 4, 2, 2, 4, 4, 4, 5, -5, 5);
    send(ewsc_pkg::CMD_ADD, 6, 9, 9, 3, 3, 1, 2, 3, -1, -2, -3);
    send(ewsc_pkg::CMD_ADD, 0, 0, 0, 5, 0, 0, 0, 0, 2, 2, 2);
    send(ewsc_pkg::CMD_CLEAR, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1);
    send(ewsc_pkg::CMD_ADD, 0, 0, 0, 0, 1, 0, 0, 0, -9, 9, -9);
    send(ewsc_pkg::CMD_ADD, 0, 0, 0, 0, 4, 0, 0, 0, 8, -8, 8);
    cur_ev = 1; cur_tr = 1; cur_kind = 1;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 11 : (phase == 1) ? 58 : 0;
      recv_idle = (phase == 0) ? 58 : (phase == 1) ? 11 : 0;
      for (int n = 0; n < 165; n++) send_random();
    end
    step_ch.valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ewsc_pkg.sv
hw/rtl/ewsc_step_if.sv
hw/rtl/ewsc_result_if.sv
hw/rtl/ewsc_datapath.sv
hw/rtl/ewsc_ctrl.sv
hw/rtl/energy_weighted_step_centroid_core.sv
tb/ewsc_centroid_checker.sv
tb/tb_energy_weighted_step_centroid_core.sv
